/* hw/rtl/bmad_pkg.sv */
// Shared types, widths and helpers for the bandwidth metered access delay block.
// No dependencies; compiled first.
package bmad_pkg;

	localparam int TIME_WIDTH = 48;
	localparam int SIZE_WIDTH = 16;
	localparam int REG_WIDTH  = 32;
	localparam int PROD_WIDTH = SIZE_WIDTH + REG_WIDTH;
	localparam int CNT_WIDTH  = $clog2(PROD_WIDTH);
	localparam int IDX_WIDTH  = 2;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic [SIZE_WIDTH-1:0] size_t;
	typedef logic [REG_WIDTH-1:0]  reg_t;
	typedef logic [PROD_WIDTH-1:0] prod_t;
	typedef logic [CNT_WIDTH-1:0]  cnt_t;
	typedef logic [IDX_WIDTH-1:0]  idx_t;

	localparam time_t TIME_MAX = '1;
	localparam cnt_t  MUL_LAST = CNT_WIDTH'(SIZE_WIDTH - 1);
	localparam cnt_t  DIV_LAST = CNT_WIDTH'(PROD_WIDTH - 1);

	// Configuration register indexes
	localparam idx_t REG_BANDWIDTH = 2'd0;
	localparam idx_t REG_CLOCK     = 2'd1;
	localparam idx_t REG_LATENCY   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_XFER,
		ST_SUM,
		ST_DONE
	} state_t;

	// Add two time values, clamp at the top of the time range
	function automatic time_t sat_add(input time_t a, input time_t b);
		logic [TIME_WIDTH:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
	endfunction

endpackage

/* hw/rtl/bmad_if.sv */
// Valid/ready channel interfaces for access requests and delay responses.
// Depends on bmad_pkg.
interface bmad_req_if;
	logic                   valid;
	logic                   ready;
	bmad_pkg::time_t        now;
	bmad_pkg::size_t        size_bytes;

	modport source (output valid, output now, output size_bytes, input ready);
	modport sink   (input valid, input now, input size_bytes, output ready);
endinterface

interface bmad_rsp_if;
	logic                   valid;
	logic                   ready;
	bmad_pkg::time_t        transfer_delay;
	bmad_pkg::time_t        completion_delay;

	modport source (output valid, output transfer_delay, output completion_delay, input ready);
	modport sink   (input valid, input transfer_delay, input completion_delay, output ready);
endinterface

/* hw/rtl/bandwidth_metered_access_delay_top.sv */
// Top level of the bandwidth metered access delay block.
// Depends on bmad_pkg and the channel interfaces in bmad_if.sv.
//
// Usage:
//   request  : one memory access per item (now, size_bytes).
//   response : one item per access (transfer_delay, completion_delay).
//   cfg_we/cfg_index/cfg_data : register writes, taken on any edge with cfg_we
//   high; write only while idle. Index 0 bandwidth, 1 clock ticks, 2 latency.
// Each access runs a bit-serial shift-add multiply (one size bit per cycle)
// and a restoring divide by the bandwidth (one quotient bit per cycle), then
// saturating sums in the XFER, SUM and DONE steps. A new item is taken only
// after the previous one has left the final step.
// request.ready is high only while no access is in flight. The result sits in
// an output register: the next item is accepted while it waits. If the
// receiver stalls, the following result holds in the final step until the
// output register frees up.
// Reset clears the channel free time to zero, bandwidth and clock ticks to
// one, latency to zero, and empties the output register.
module bandwidth_metered_access_delay_top (
	input  logic                 clk,
	input  logic                 arst_n,
	bmad_req_if.sink             request,
	bmad_rsp_if.source           response,
	input  logic                 cfg_we,
	input  bmad_pkg::idx_t       cfg_index,
	input  bmad_pkg::reg_t       cfg_data
);
	import bmad_pkg::*;

	state_t state_q, state_d;
	cnt_t   cnt_q;
	logic   accept, load_out;

	reg_t   bw_q, clk_q, lat_q;
	time_t  free_q;
	logic   out_valid_q;

	time_t  now_q, backlog_q, xfer_q, delay_q;
	size_t  size_q;
	prod_t  prod_q, dvd_q;
	reg_t   rem_q;
	logic   zero_q;
	time_t  transfer_q, completion_q;

	// Backlog: remaining busy time, zero when the channel is idle
	logic [TIME_WIDTH:0]  backlog_diff;
	// Divider step
	logic [REG_WIDTH:0]   trial, trial_diff;
	logic                 trial_ge;

	assign backlog_diff = {1'b0, free_q} - {1'b0, request.now};
	assign trial        = {rem_q, dvd_q[PROD_WIDTH-1]};
	assign trial_diff   = trial - {1'b0, bw_q};
	assign trial_ge     = !trial_diff[REG_WIDTH];

	assign accept           = request.valid && request.ready;
	assign request.ready    = (state_q == ST_IDLE);
	assign response.valid   = out_valid_q;
	assign response.transfer_delay   = transfer_q;
	assign response.completion_delay = completion_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) state_d = ST_PREP;
			end
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) state_d = ST_XFER;
			end
			ST_XFER: state_d = ST_SUM;
			ST_SUM:  state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || response.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state: config, channel free time, output valid, step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q        <= reg_t'(1);
			clk_q       <= reg_t'(1);
			lat_q       <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BANDWIDTH: bw_q  <= cfg_data;
					REG_CLOCK:     clk_q <= cfg_data;
					REG_LATENCY:   lat_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) begin
				free_q      <= sat_add(now_q, delay_q);
				out_valid_q <= 1'b1;
			end else if (response.ready) begin
				out_valid_q <= 1'b0;
			end
			if ((state_q == ST_MUL && cnt_q != MUL_LAST) ||
			    (state_q == ST_DIV && cnt_q != DIV_LAST)) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// Serial datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					now_q     <= request.now;
					size_q    <= request.size_bytes;
					prod_q    <= '0;
					backlog_q <= backlog_diff[TIME_WIDTH] ? '0 : backlog_diff[TIME_WIDTH-1:0];
				end
			end
			// shift-add multiply, size MSB first
			ST_MUL: begin
				prod_q <= {prod_q[PROD_WIDTH-2:0], 1'b0} +
				          (size_q[SIZE_WIDTH-1] ? PROD_WIDTH'(clk_q) : '0);
				size_q <= {size_q[SIZE_WIDTH-2:0], 1'b0};
			end
			ST_PREP: begin
				zero_q <= (prod_q == '0);
				dvd_q  <= prod_q - prod_t'(1);
				rem_q  <= '0;
			end
			// restoring divide, quotient bits shift into the dividend register
			ST_DIV: begin
				rem_q <= trial_ge ? trial_diff[REG_WIDTH-1:0] : trial[REG_WIDTH-1:0];
				dvd_q <= {dvd_q[PROD_WIDTH-2:0], trial_ge};
			end
			ST_XFER: begin
				if (bw_q == '0)  xfer_q <= TIME_MAX;
				else if (zero_q) xfer_q <= '0;
				else             xfer_q <= sat_add(TIME_WIDTH'(dvd_q), time_t'(1));
			end
			ST_SUM: delay_q <= sat_add(xfer_q, backlog_q);
			ST_DONE: begin
				if (load_out) begin
					transfer_q   <= delay_q;
					completion_q <= sat_add(TIME_WIDTH'(lat_q), delay_q);
				end
			end
			default: ;
		endcase
	end

	// Checks
	a_out_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(response.valid && response.ready && !load_out) |=> !response.valid)
		else $error("response valid held after item was taken");

	a_free_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (free_q >= now_q))
		else $error("channel free time behind access time");

	a_compl_ge: assert property (@(posedge clk) disable iff (!arst_n)
		response.valid |-> (response.completion_delay >= response.transfer_delay))
		else $error("completion delay below transfer delay");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && bw_q != '0) |-> (rem_q < bw_q))
		else $error("divider remainder out of range");

endmodule
